FILE: rtl/core/spg_pkg.sv
// Shared types, constants and helper functions for the stepper pulse ramp generator.
`timescale 1ns / 1ps

package spg_pkg;

    // Default sizes of the step and ramp counters
    localparam int COUNT_BITS_DEF = 24;
    localparam int RAMP_BITS_DEF  = 16;

    // Fixed field widths
    localparam int PERIOD_W = 32;   // Q16.16 half-period in microseconds
    localparam int US_W     = 16;   // integer microseconds
    localparam int FRAC_W   = 16;   // fraction bits of the period
    localparam int FACTOR_W = 16;   // Q0.16 acceleration multiplier
    localparam int INVERSE_W = 17;  // Q1.16 deceleration multiplier
    localparam int STEPS_W  = 24;   // step count field on the request
    localparam int TICK_W   = 7;    // ticks per half pulse, at most 65
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // Microseconds to milliseconds: floor(us / 1000) = (us * 67109) >> 26 on 16 bits
    localparam int MS_RECIP_W = 17;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = 17'd67109;
    localparam int MS_SHIFT = 26;

    // Register reset values
    localparam logic [US_W-1:0]      START_PERIOD_RST = 16'd20000;
    localparam logic [FACTOR_W-1:0]  RAMP_FACTOR_RST  = 16'd62259;
    localparam logic [INVERSE_W-1:0] RAMP_INVERSE_RST = 17'd68985;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FACTOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INVERSE = 2'd2;

    // Request kinds
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } t_phase;

    // Outcome of choosing the next pulse
    typedef struct packed {
        t_phase phase;
        logic   pulse;
    } t_adv_status;

    // Ticks for one half of a pulse: max(1, floor(us / 1000))
    function automatic logic [TICK_W-1:0] half_ticks(input logic [US_W-1:0] us);
        logic [US_W+MS_RECIP_W-1:0] prod;
        logic [TICK_W-1:0]          t;
        prod = (US_W+MS_RECIP_W)'(us) * (US_W+MS_RECIP_W)'(MS_RECIP);
        t    = prod[MS_SHIFT +: TICK_W];
        return (t == '0) ? TICK_W'(1) : t;
    endfunction

endpackage

FILE: rtl/core/spg_advance.sv
// Next-pulse selection: ramp, cruise and decel decisions with one shared multiplier.
`timescale 1ns / 1ps

module spg_advance #(
    parameter int COUNT_BITS = spg_pkg::COUNT_BITS_DEF,
    parameter int RAMP_BITS  = spg_pkg::RAMP_BITS_DEF
) (
    input  spg_pkg::t_phase                    i_phase,
    input  logic [spg_pkg::PERIOD_W-1:0]       i_period,
    input  logic [spg_pkg::US_W-1:0]           i_target,
    input  logic [RAMP_BITS-1:0]               i_ramp,
    input  logic [COUNT_BITS-1:0]              i_steps,
    input  logic [spg_pkg::FACTOR_W-1:0]       i_ramp_factor,
    input  logic [spg_pkg::INVERSE_W-1:0]      i_ramp_inverse,
    output spg_pkg::t_adv_status               o_status,
    output logic [spg_pkg::PERIOD_W-1:0]       o_period,
    output logic [RAMP_BITS-1:0]               o_ramp,
    output logic [COUNT_BITS-1:0]              o_steps
);

    localparam int CW = (COUNT_BITS > RAMP_BITS + 1) ? COUNT_BITS : RAMP_BITS + 1;
    localparam int PW = spg_pkg::PERIOD_W;
    localparam int MW = spg_pkg::INVERSE_W;
    localparam int FW = spg_pkg::FRAC_W;

    logic [PW-1:0]    tgt_fx;
    logic             accel_step;
    logic [MW-1:0]    mult_op;
    logic [PW+MW-1:0] prod;
    logic [PW-1:0]    acc_p;
    logic [PW-1:0]    acc_clamped;
    logic [PW-1:0]    dec_p;
    logic [CW-1:0]    twice;
    logic [CW-1:0]    steps_x;
    logic [CW-1:0]    steps_rest;
    logic             cruise_after_ramp;
    logic             decel_go;
    logic [RAMP_BITS-1:0] ramp_inc;

    assign tgt_fx     = {i_target, {FW{1'b0}}};
    assign accel_step = (i_phase == spg_pkg::PH_ACCEL) && (i_period > tgt_fx);

    // Share the multiplier: accelerate factor while ramping up, inverse otherwise
    assign mult_op = accel_step ? MW'(i_ramp_factor) : i_ramp_inverse;
    assign prod    = (PW+MW)'(i_period) * (PW+MW)'(mult_op);

    assign acc_p       = prod[FW +: PW];
    assign acc_clamped = (acc_p < tgt_fx) ? tgt_fx : acc_p;
    assign dec_p       = prod[PW+MW-1] ? {PW{1'b1}} : prod[FW +: PW];

    assign twice             = CW'({i_ramp, 1'b0});
    assign steps_x           = CW'(i_steps);
    assign cruise_after_ramp = steps_x > twice;
    assign steps_rest        = steps_x - twice - CW'(1);
    assign decel_go          = (i_ramp != '0);
    assign ramp_inc          = (i_ramp == '1) ? i_ramp : i_ramp + RAMP_BITS'(1);

    always_comb begin
        o_status.phase = spg_pkg::PH_IDLE;
        o_status.pulse = 1'b0;
        o_period       = i_period;
        o_ramp         = i_ramp;
        o_steps        = i_steps;
        case (i_phase)
            spg_pkg::PH_ACCEL: begin
                if (accel_step) begin
                    o_status.phase = spg_pkg::PH_ACCEL;
                    o_status.pulse = 1'b1;
                    o_period       = acc_clamped;
                    o_ramp         = ramp_inc;
                end else if (cruise_after_ramp) begin
                    o_status.phase = spg_pkg::PH_CRUISE;
                    o_status.pulse = 1'b1;
                    o_steps        = steps_rest[COUNT_BITS-1:0];
                end else if (decel_go) begin
                    o_status.phase = spg_pkg::PH_DECEL;
                    o_status.pulse = 1'b1;
                    o_steps        = '0;
                    o_period       = dec_p;
                    o_ramp         = i_ramp - RAMP_BITS'(1);
                end else begin
                    o_steps = '0;
                end
            end
            spg_pkg::PH_CRUISE: begin
                if (i_steps != '0) begin
                    o_status.phase = spg_pkg::PH_CRUISE;
                    o_status.pulse = 1'b1;
                    o_steps        = i_steps - COUNT_BITS'(1);
                end else if (decel_go) begin
                    o_status.phase = spg_pkg::PH_DECEL;
                    o_status.pulse = 1'b1;
                    o_period       = dec_p;
                    o_ramp         = i_ramp - RAMP_BITS'(1);
                end
            end
            spg_pkg::PH_DECEL: begin
                if (decel_go) begin
                    o_status.phase = spg_pkg::PH_DECEL;
                    o_status.pulse = 1'b1;
                    o_period       = dec_p;
                    o_ramp         = i_ramp - RAMP_BITS'(1);
                end
            end
            default: begin
                o_status.phase = spg_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/stepper_pulse_ramp_generator.sv
// Top level of the stepper step pulse generator with acceleration and deceleration ramps.
`timescale 1ns / 1ps
//
//  channel   | direction | handshake                        | content
//  ----------+-----------+----------------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready    | tick or start request
//  m_axis    | out       | m_axis_tvalid / m_axis_tready    | step, dir, busy, move done
//  cfg       | in        | i_cfg_valid / o_cfg_ready        | register index and value
//
//  One request per clock while the result side is not stalled. Each accepted request
//  updates the motion state and loads the result register in the same cycle; the result
//  shows in the next cycle. The critical path runs through the shared 32x17 period multiplier
//  in spg_advance. Reset (i_rst_n low at a clock edge) resets the motion state and loads the
//  register defaults. s_axis_tready drops only while a result is held and
//  m_axis_tready is low; cfg writes are always taken.

module stepper_pulse_ramp_generator #(
    parameter int COUNT_BITS = spg_pkg::COUNT_BITS_DEF,
    parameter int RAMP_BITS  = spg_pkg::RAMP_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] dir_positive, [24:1] step_count, [25] accelerate, [41:26] half_period_us, [47:42] 0
    input  logic [47:0]                      s_axis_tdata,
    // [0] command
    input  logic                             s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] step_level, [1] dir_level, [2] busy_res, [7:3] 0
    output logic [7:0]                       m_axis_tdata,
    // move_done
    output logic                             m_axis_tlast,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PW = spg_pkg::PERIOD_W;
    localparam int UW = spg_pkg::US_W;
    localparam int TW = spg_pkg::TICK_W;
    localparam int SW = spg_pkg::STEPS_W;

    // Unpack the request
    logic            in_cmd;
    logic            in_dir;
    logic [SW-1:0]   in_step_count;
    logic            in_accel;
    logic [UW-1:0]   in_half_period;
    logic [COUNT_BITS+SW-1:0] in_steps_wide;
    logic [COUNT_BITS-1:0]    in_steps;

    assign in_cmd         = s_axis_tuser;
    assign in_dir         = s_axis_tdata[0];
    assign in_step_count  = s_axis_tdata[SW:1];
    assign in_accel       = s_axis_tdata[SW+1];
    assign in_half_period = s_axis_tdata[SW+2 +: UW];
    // Mask or widen the count to COUNT_BITS
    assign in_steps_wide  = {{COUNT_BITS{1'b0}}, in_step_count};
    assign in_steps       = in_steps_wide[COUNT_BITS-1:0];

    // Configuration registers
    logic [UW-1:0]                      r_start_period;
    logic [spg_pkg::FACTOR_W-1:0]       r_ramp_factor;
    logic [spg_pkg::INVERSE_W-1:0]      r_ramp_inverse;

    // Motion state
    spg_pkg::t_phase          r_phase, n_phase;
    logic                     r_pulse, n_pulse;
    logic                     r_dir, n_dir;
    logic [PW-1:0]            r_period, n_period;
    logic [UW-1:0]            r_target, n_target;
    logic [TW-1:0]            r_ticks, n_ticks;
    // Set when the half-pulse length must be taken from the current period
    logic                     r_fresh, n_fresh;
    logic [RAMP_BITS-1:0]     r_ramp, n_ramp;
    logic [COUNT_BITS-1:0]    r_steps, n_steps;
    logic                     n_done;

    // Result register
    logic                     r_out_valid;
    logic                     r_out_step;
    logic                     r_out_dir;
    logic                     r_out_busy;
    logic                     r_out_done;

    logic                     accept;
    logic                     is_start;
    logic [TW-1:0]            ticks_eff;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_start      = (in_cmd == spg_pkg::CMD_START);
    assign o_cfg_ready   = 1'b1;

    // Half-pulse length is resolved one request after the period changed,
    // which keeps the period multiply and the ms conversion in separate cycles.
    assign ticks_eff = r_fresh
        ? spg_pkg::half_ticks((r_phase == spg_pkg::PH_CRUISE) ? r_target : r_period[PW-1 -: UW])
        : r_ticks;

    // Next-pulse selection, fed from the start request or the running state
    spg_pkg::t_phase          adv_phase;
    logic [PW-1:0]            adv_period;
    logic [UW-1:0]            adv_target;
    logic [RAMP_BITS-1:0]     adv_ramp;
    logic [COUNT_BITS-1:0]    adv_steps;
    spg_pkg::t_adv_status     adv_status;
    logic [PW-1:0]            adv_period_n;
    logic [RAMP_BITS-1:0]     adv_ramp_n;
    logic [COUNT_BITS-1:0]    adv_steps_n;

    always_comb begin
        if (is_start) begin
            adv_phase  = in_accel ? spg_pkg::PH_ACCEL : spg_pkg::PH_CRUISE;
            adv_period = in_accel ? {r_start_period, {spg_pkg::FRAC_W{1'b0}}} : r_period;
            adv_target = in_half_period;
            adv_ramp   = '0;
            adv_steps  = in_steps;
        end else begin
            adv_phase  = r_phase;
            adv_period = r_period;
            adv_target = r_target;
            adv_ramp   = r_ramp;
            adv_steps  = r_steps;
        end
    end

    spg_advance #(
        .COUNT_BITS (COUNT_BITS),
        .RAMP_BITS  (RAMP_BITS)
    ) u_advance (
        .i_phase        (adv_phase),
        .i_period       (adv_period),
        .i_target       (adv_target),
        .i_ramp         (adv_ramp),
        .i_steps        (adv_steps),
        .i_ramp_factor  (r_ramp_factor),
        .i_ramp_inverse (r_ramp_inverse),
        .o_status       (adv_status),
        .o_period       (adv_period_n),
        .o_ramp         (adv_ramp_n),
        .o_steps        (adv_steps_n)
    );

    // Next motion state
    always_comb begin
        n_phase  = r_phase;
        n_pulse  = r_pulse;
        n_dir    = r_dir;
        n_period = r_period;
        n_target = r_target;
        n_ticks  = r_ticks;
        n_fresh  = r_fresh;
        n_ramp   = r_ramp;
        n_steps  = r_steps;
        n_done   = 1'b0;
        if (accept) begin
            if (is_start) begin
                // Start while busy is dropped
                if (r_phase == spg_pkg::PH_IDLE) begin
                    n_dir    = in_dir;
                    n_target = in_half_period;
                    n_phase  = adv_status.phase;
                    n_period = adv_period_n;
                    n_ramp   = adv_ramp_n;
                    n_steps  = adv_steps_n;
                    if (adv_status.pulse) begin
                        n_pulse = 1'b1;
                        n_fresh = 1'b1;
                    end
                end
            end else if (r_phase != spg_pkg::PH_IDLE) begin
                if (ticks_eff > TW'(1)) begin
                    // Count down the current half
                    n_ticks = ticks_eff - TW'(1);
                    n_fresh = 1'b0;
                end else if (r_pulse) begin
                    // High half over: go low for the same length
                    n_pulse = 1'b0;
                    n_fresh = 1'b1;
                end else begin
                    // Low half over: pick the next pulse or end the move
                    n_phase  = adv_status.phase;
                    n_period = adv_period_n;
                    n_ramp   = adv_ramp_n;
                    n_steps  = adv_steps_n;
                    if (adv_status.pulse) begin
                        n_pulse = 1'b1;
                        n_fresh = 1'b1;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
        end
    end

    // Motion state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= spg_pkg::PH_IDLE;
            r_pulse  <= 1'b1;
            r_dir    <= 1'b0;
            r_period <= '0;
            r_target <= '0;
            r_ticks  <= '0;
            r_fresh  <= 1'b0;
            r_ramp   <= '0;
            r_steps  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pulse  <= n_pulse;
            r_dir    <= n_dir;
            r_period <= n_period;
            r_target <= n_target;
            r_ticks  <= n_ticks;
            r_fresh  <= n_fresh;
            r_ramp   <= n_ramp;
            r_steps  <= n_steps;
        end
    end

    // Configuration writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_period <= spg_pkg::START_PERIOD_RST;
            r_ramp_factor  <= spg_pkg::RAMP_FACTOR_RST;
            r_ramp_inverse <= spg_pkg::RAMP_INVERSE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spg_pkg::CFG_START_PERIOD: r_start_period <= i_cfg_data[UW-1:0];
                spg_pkg::CFG_RAMP_FACTOR:  r_ramp_factor  <= i_cfg_data[spg_pkg::FACTOR_W-1:0];
                spg_pkg::CFG_RAMP_INVERSE: r_ramp_inverse <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Result register: load on every accepted request, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_step <= n_pulse;
            r_out_dir  <= n_dir;
            r_out_busy <= (n_phase != spg_pkg::PH_IDLE);
            r_out_done <= n_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_busy, r_out_dir, r_out_step};
    assign m_axis_tlast  = r_out_done;

`ifndef SYNTHESIS
    // A finished move reports idle in the same result
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[2])
        else $error("move done reported while busy");

    // Every accepted request produces a result on the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted request without result");

    // A stored half-pulse count is never zero while a move runs
    a_ticks_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_fresh && r_phase != spg_pkg::PH_IDLE) |-> (r_ticks != '0))
        else $error("zero tick count during a move");

    // With no result held the request side stays open
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("request stalled with empty result register");
`endif

endmodule

FILE: verif/spg_step_checker.sv
// Checker for the stepper pulse ramp generator: predicts each result and compares it.
`timescale 1ns / 1ps

module spg_step_checker
    import spg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [7:0]            m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int unsigned US_PER_MS = 1000;
    localparam logic [RAMP_BITS_DEF-1:0] RAMP_TOP = '1;
    localparam int MAX_PRINTS = 30;

    typedef struct packed {
        logic step;
        logic dir;
        logic busy;
        logic done;
    } t_step_out;

    // motion state
    t_phase                     mot_phase;
    logic                       step_lvl;
    logic                       dir_lvl;
    logic [PERIOD_W-1:0]        period_q;
    logic [US_W-1:0]            target_us;
    logic [15:0]                half_left;
    logic [RAMP_BITS_DEF-1:0]   ramp_cnt;
    logic [COUNT_BITS_DEF-1:0]  pulses_left;

    // register copies
    logic [US_W-1:0]      cfg_start_us;
    logic [FACTOR_W-1:0]  cfg_accel_mul;
    logic [INVERSE_W-1:0] cfg_decel_mul;

    t_step_out expected_outs[$];
    t_step_out want;
    t_step_out got;
    int        err_cnt = 0;
    int        cmp_cnt = 0;
    int        pend_cnt = 0;

    assign o_mismatches = err_cnt;
    assign o_pending    = pend_cnt;
    assign o_checked    = cmp_cnt;

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH result %0d: %s", $time, cmp_cnt, msg);
        end
    endtask

    // Cruise runs at the target; ramps use the live Q16.16 period.
    function automatic logic [15:0] ticks_per_half();
        logic [US_W-1:0] us;
        int unsigned     t;
        us = (mot_phase == PH_CRUISE) ? target_us : period_q[31:16];
        t  = us / US_PER_MS;
        return (t == 0) ? 16'd1 : 16'(t);
    endfunction

    function automatic void load_pulse();
        step_lvl  = 1'b1;
        half_left = ticks_per_half();
    endfunction

    // Pick the next pulse of the move; returns 0 once the move is over.
    function automatic bit next_pulse();
        logic [47:0] floor_q;
        logic [47:0] acc_prod;
        logic [48:0] dec_prod;
        int unsigned twice;
        if (mot_phase == PH_ACCEL) begin
            floor_q = {target_us, 16'h0000};
            if ({16'h0000, period_q} > floor_q) begin
                acc_prod = ({16'h0000, period_q} * {32'h0, cfg_accel_mul}) >> 16;
                if (acc_prod < floor_q) begin
                    acc_prod = floor_q;
                end
                period_q = acc_prod[31:0];
                if (ramp_cnt != RAMP_TOP) begin
                    ramp_cnt++;
                end
                load_pulse();
                return 1'b1;
            end
            // ramp done: both ramps come out of the requested count
            twice = 2 * ramp_cnt;
            pulses_left = (pulses_left > twice) ? 24'(pulses_left - twice) : '0;
            mot_phase = PH_CRUISE;
        end
        if (mot_phase == PH_CRUISE) begin
            if (pulses_left != 0) begin
                pulses_left--;
                load_pulse();
                return 1'b1;
            end
            mot_phase = PH_DECEL;
        end
        if (mot_phase == PH_DECEL && ramp_cnt != 0) begin
            dec_prod = ({17'h0, period_q} * {32'h0, cfg_decel_mul}) >> 16;
            period_q = (dec_prod[48:32] != 0) ? 32'hFFFF_FFFF : dec_prod[31:0];
            ramp_cnt--;
            load_pulse();
            return 1'b1;
        end
        mot_phase = PH_IDLE;
        return 1'b0;
    endfunction

    function automatic t_step_out apply_request(input logic cmd, input logic [47:0] pl);
        t_step_out r;
        bit        ended;
        ended = 1'b0;
        if (cmd == CMD_START) begin
            if (mot_phase == PH_IDLE) begin
                dir_lvl     = pl[0];
                pulses_left = pl[24:1];
                target_us   = pl[41:26];
                ramp_cnt    = '0;
                if (pl[25]) begin
                    period_q  = {cfg_start_us, 16'h0000};
                    mot_phase = PH_ACCEL;
                end else begin
                    mot_phase = PH_CRUISE;
                end
                void'(next_pulse());
            end
        end else if (mot_phase != PH_IDLE) begin
            if (half_left > 1) begin
                half_left--;
            end else if (step_lvl) begin
                step_lvl  = 1'b0;
                half_left = ticks_per_half();
            end else begin
                half_left = '0;
                ended = !next_pulse();
            end
        end
        r.step = step_lvl;
        r.dir  = dir_lvl;
        r.busy = (mot_phase != PH_IDLE);
        r.done = ended;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mot_phase     = PH_IDLE;
            step_lvl      = 1'b1;
            dir_lvl       = 1'b0;
            period_q      = '0;
            target_us     = '0;
            half_left     = '0;
            ramp_cnt      = '0;
            pulses_left   = '0;
            cfg_start_us  = START_PERIOD_RST;
            cfg_accel_mul = RAMP_FACTOR_RST;
            cfg_decel_mul = RAMP_INVERSE_RST;
            expected_outs.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_PERIOD: cfg_start_us  = i_cfg_data[US_W-1:0];
                    CFG_RAMP_FACTOR:  cfg_accel_mul = i_cfg_data[FACTOR_W-1:0];
                    CFG_RAMP_INVERSE: cfg_decel_mul = i_cfg_data[INVERSE_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_outs.push_back(apply_request(s_axis_tuser, s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.step = m_axis_tdata[0];
                got.dir  = m_axis_tdata[1];
                got.busy = m_axis_tdata[2];
                got.done = m_axis_tlast;
                if (expected_outs.size() == 0) begin
                    report_mismatch($sformatf("result %b with nothing expected", got));
                end else begin
                    want = expected_outs.pop_front();
                    if (got.step !== want.step)
                        report_mismatch($sformatf("step_level exp %b got %b", want.step, got.step));
                    if (got.dir !== want.dir)
                        report_mismatch($sformatf("dir_level exp %b got %b", want.dir, got.dir));
                    if (got.busy !== want.busy)
                        report_mismatch($sformatf("busy exp %b got %b", want.busy, got.busy));
                    if (got.done !== want.done)
                        report_mismatch($sformatf("move_done exp %b got %b", want.done, got.done));
                end
                cmp_cnt++;
            end
        end
        pend_cnt = expected_outs.size();
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the stepper pulse ramp generator: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb;
    import spg_pkg::*;

    localparam int HALF_CLK = 10;
    // index past the register list; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 320;
    localparam int PHASE_ITEMS  = 100;
    localparam int IDLE_PCT     = 14;
    // far beyond the slowest legal run
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [47:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = CMD_TICK;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [7:0]            m_axis_tdata;
    wire                   m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    wire                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int mismatches;
    int pending;
    int checked;

    // stimulus bookkeeping
    bit steady = 1'b0;      // no idling on either side while set
    bit move_busy = 1'b0;   // busy flag of the last result taken
    int sent_items = 0;
    int move_cnt = 0;
    int tick_cnt = 0;
    int ignored_starts = 0;
    int reg_writes = 0;
    int rand_base;
    int phase_mark;
    int phase_no;

    always #HALF_CLK i_clk = ~i_clk;

    stepper_pulse_ramp_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    spg_step_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Stall the result side at random, except during steady stretches.
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Track whether the block still reports a move in progress.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            move_busy <= m_axis_tdata[2];
        end
    end

    // Field order on tdata, lowest bit first: dir, step count, accelerate, half-period.
    function automatic logic [47:0] pack_move(input logic dir, input logic [23:0] cnt,
                                              input logic acc, input logic [15:0] hp);
        return {6'b0, hp, acc, cnt, dir};
    endfunction

    function automatic logic [47:0] rand_payload();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        v[47:42] = '0;
        return v;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic push_request(input logic cmd, input logic [47:0] payload);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= payload;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Tick fields are don't-care, so send noise in them.
    task automatic tick_burst(input int n);
        repeat (n) begin
            push_request(CMD_TICK, rand_payload());
            tick_cnt++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Start a move, then tick in bursts until the block reports idle. A start
    // placed at the head of a burst is always one the busy block must ignore,
    // since the preceding settle showed it busy.
    task automatic run_move(input logic dir, input logic [23:0] cnt, input logic acc,
                            input logic [15:0] hp, input int burst_max, input bit noisy);
        push_request(CMD_START, pack_move(dir, cnt, acc, hp));
        move_cnt++;
        settle();
        while (move_busy) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                push_request(CMD_START, rand_payload());
                ignored_starts++;
            end
            tick_burst($urandom_range(1, burst_max));
            settle();
        end
    endtask

    // Keep the decel multiplier near the inverse of the accel one so that
    // ramps come back down in a bounded number of ticks; now and then go
    // below one so deceleration shrinks the period.
    task automatic random_profile();
        logic [FACTOR_W-1:0]  f;
        logic [INVERSE_W-1:0] inv;
        int unsigned          base;
        f = 16'($urandom_range(33000, 60000));
        if ($urandom_range(0, 4) == 0) begin
            inv = 17'($urandom_range(1, 65535));
        end else begin
            base = 32'hFFFF_FFFF / f + $urandom_range(0, 200) - 100;
            inv  = (base > 131071) ? 17'd131071 : 17'(base);
        end
        // bit 16 is outside the 16-bit registers and must be dropped
        write_reg(CFG_RAMP_FACTOR, {1'($urandom), f});
        write_reg(CFG_START_PERIOD, {1'($urandom), 16'($urandom_range(1, 6000))});
        write_reg(CFG_RAMP_INVERSE, inv);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_SPARE, 17'($urandom));
        end
    endtask

    // Mostly short moves at short periods; a few at long half-periods with few pulses.
    task automatic random_move();
        logic        dir;
        logic        acc;
        logic [15:0] hp;
        logic [23:0] cnt;
        dir = 1'($urandom);
        acc = 1'($urandom);
        if ($urandom_range(0, 7) == 0) hp = 16'($urandom);
        else hp = 16'($urandom_range(0, 2500));
        if (hp > 4000) cnt = 24'($urandom_range(0, 3));
        else if ($urandom_range(0, 9) == 0) cnt = 24'($urandom_range(7, 40));
        else cnt = 24'($urandom_range(0, 6));
        // ticks while idle must change nothing
        if ($urandom_range(0, 7) == 0) begin
            tick_burst($urandom_range(1, 3));
            settle();
        end
        run_move(dir, cnt, acc, hp, 24, 1'b1);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the register defaults
        tick_burst(1);                                  // tick with no move
        settle();
        run_move(1'b1, 24'd0, 1'b0, 16'd1234, 8, 1'b0); // no pulses: latch dir only
        run_move(1'b0, 24'd1, 1'b0, 16'd0, 4, 1'b0);    // zero period, one tick halves
        run_move(1'b1, 24'd1, 1'b0, 16'hFFFF, 32, 1'b1);// longest halves, busy starts
        run_move(1'b0, 24'd2, 1'b0, 16'd999, 8, 1'b0);  // tick rounding edges
        run_move(1'b1, 24'd1, 1'b0, 16'd1000, 8, 1'b0);
        run_move(1'b0, 24'd1, 1'b0, 16'd1999, 8, 1'b0);
        run_move(1'b1, 24'd1, 1'b0, 16'd2000, 8, 1'b0);
        run_move(1'b1, 24'd3, 1'b1, 16'd19500, 24, 1'b1); // one ramp pulse each way, one cruise
        run_move(1'b0, 24'd0, 1'b1, 16'd19000, 24, 1'b0); // zero count still ramps
        run_move(1'b1, 24'd1, 1'b1, 16'd30000, 24, 1'b0); // target above start: cruise
        run_move(1'b0, 24'd0, 1'b1, 16'd25000, 8, 1'b0);  // nothing to run at all

        // Extreme registers: one-step ramp, decel saturates the period
        write_reg(CFG_START_PERIOD, 17'd65535);
        write_reg(CFG_RAMP_FACTOR, 17'd1);
        write_reg(CFG_RAMP_INVERSE, 17'd131071);
        run_move(1'b1, 24'd2, 1'b1, 16'd33000, 40, 1'b1);
        run_move(1'b0, 24'd3, 1'b1, 16'd700, 16, 1'b1);

        // Smallest start period (bit 16 dropped), unit decel, spare index
        write_reg(CFG_START_PERIOD, 17'h1_0001);
        write_reg(CFG_RAMP_FACTOR, 17'd40000);
        write_reg(CFG_RAMP_INVERSE, 17'd65536);
        write_reg(CFG_SPARE, 17'h1_ABCD);
        run_move(1'b1, 24'd2, 1'b1, 16'd0, 16, 1'b1);

        // Longer ramp at sub-tick periods, bit 16 of the factor dropped, no idling
        steady = 1'b1;
        write_reg(CFG_START_PERIOD, 17'd1999);
        write_reg(CFG_RAMP_FACTOR, 17'h1_F000);
        write_reg(CFG_RAMP_INVERSE, 17'd65537);
        run_move(1'b1, 24'd5, 1'b1, 16'd500, 64, 1'b0);
        steady = 1'b0;

        // Random part: several register settings, one of them without idling
        rand_base = sent_items;
        phase_no  = 0;
        while (sent_items - rand_base < RANDOM_ITEMS) begin
            random_profile();
            steady     = (phase_no == 2);
            phase_mark = sent_items;
            while (sent_items - phase_mark < PHASE_ITEMS) begin
                random_move();
            end
            steady = 1'b0;
            phase_no++;
        end

        settle();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d moves with %0d ticks, %0d starts sent while busy, %0d register writes.",
                 move_cnt, tick_cnt, ignored_starts, reg_writes);
        $display("Compared %0d results over %0d requests; %0d mismatches.",
                 checked, sent_items, mismatches);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still outstanding.", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: stepper_pulse_ramp_generator.f
rtl/core/spg_pkg.sv
rtl/core/spg_advance.sv
rtl/core/stepper_pulse_ramp_generator.sv
verif/spg_step_checker.sv
verif/tb.sv
